@@ rtl/lrudc_pkg.sv @@
package lrudc_pkg;

  // Store geometry.
  localparam int ENTRIES      = 16;
  localparam int KEY_BITS     = 64;
  localparam int CONTENT_BITS = 64;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int RANK_W       = IDX_W;
  localparam int FILL_W       = $clog2(ENTRIES + 1);

  // Outcome codes reported with each result.
  localparam logic [1:0] OUTCOME_HIT     = 2'd0;
  localparam logic [1:0] OUTCOME_REPLACE = 2'd1;
  localparam logic [1:0] OUTCOME_INSERT  = 2'd2;
  localparam logic [1:0] OUTCOME_EVICT   = 2'd3;

  typedef struct packed {
    logic [63:0] fingerprint_key;
    logic [63:0] content_word;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] outcome;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CMP,
    ST_FIN
  } state_t;

  // Update request to the recency table.
  typedef struct packed {
    logic             en;
    logic             insert;
    logic [IDX_W-1:0] slot;
  } rank_op_t;

endpackage

@@ rtl/lru_dedup_chunk_cache.sv @@
// An input taken in ST_IDLE goes straight to ST_FIN if the store is empty;
// else each stored entry gets ST_LOOK (RAM read), then ST_CMP (compare),
// until a key match or the last stored entry, and ST_FIN loads the result.
// The next input is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous) clears valid bits, ranks and fill count.
module lru_dedup_chunk_cache (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lrudc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lrudc_pkg::out_item_t out_data
);

  logic                                ram_rd_en;
  logic [lrudc_pkg::IDX_W-1:0]         ram_rd_addr;
  logic [lrudc_pkg::KEY_BITS-1:0]      key_rd_data;
  logic [lrudc_pkg::CONTENT_BITS-1:0]  content_rd_data;
  logic                                key_wr_en;
  logic                                content_wr_en;
  logic [lrudc_pkg::IDX_W-1:0]         ram_wr_addr;
  logic [lrudc_pkg::KEY_BITS-1:0]      key_wr_data;
  logic [lrudc_pkg::CONTENT_BITS-1:0]  content_wr_data;
  logic [lrudc_pkg::IDX_W-1:0]         rank_idx;
  logic [lrudc_pkg::RANK_W-1:0]        rank_rd;
  lrudc_pkg::rank_op_t                 rank_op;
  logic [lrudc_pkg::FILL_W-1:0]        fill;

  // Sequencer with the shared key and content comparator.
  lrudc_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .key_rd_data     (key_rd_data),
    .content_rd_data (content_rd_data),
    .key_wr_en       (key_wr_en),
    .content_wr_en   (content_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .key_wr_data     (key_wr_data),
    .content_wr_data (content_wr_data),
    .rank_idx        (rank_idx),
    .rank_rd         (rank_rd),
    .rank_op         (rank_op),
    .fill            (fill)
  );

  // Stored keys.
  lrudc_ram #(
    .WIDTH (lrudc_pkg::KEY_BITS),
    .DEPTH (lrudc_pkg::ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (key_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (key_rd_data)
  );

  // Stored contents.
  lrudc_ram #(
    .WIDTH (lrudc_pkg::CONTENT_BITS),
    .DEPTH (lrudc_pkg::ENTRIES)
  ) u_content_ram (
    .clk     (clk),
    .wr_en   (content_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (content_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (content_rd_data)
  );

  // Valid bits, recency ranks and fill count.
  lrudc_rank u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rank_idx),
    .rd_rank (rank_rd),
    .op      (rank_op),
    .fill    (fill)
  );

endmodule

@@ rtl/lrudc_ram.sv @@
module lrudc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/lrudc_rank.sv @@
module lrudc_rank (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lrudc_pkg::IDX_W-1:0]       rd_idx,
  output logic [lrudc_pkg::RANK_W-1:0]      rd_rank,
  input  lrudc_pkg::rank_op_t               op,
  output logic [lrudc_pkg::FILL_W-1:0]      fill
);

  logic [lrudc_pkg::RANK_W-1:0] rank_r   [lrudc_pkg::ENTRIES];
  logic [lrudc_pkg::RANK_W-1:0] rank_nxt [lrudc_pkg::ENTRIES];
  logic [lrudc_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [lrudc_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [lrudc_pkg::RANK_W-1:0]  slot_rank;

  assign rd_rank   = rank_r[rd_idx];
  assign fill      = fill_r;
  assign slot_rank = rank_r[op.slot];

  // Insert ages every valid entry; promote ages only the entries more
  // recent than the touched one. The touched slot becomes rank zero.
  always_comb begin
    rank_nxt  = rank_r;
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    if (op.en) begin
      for (int i = 0; i < lrudc_pkg::ENTRIES; i++) begin
        if (op.insert) begin
          if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end else if (valid_r[i] && (lrudc_pkg::IDX_W'(i) != op.slot) &&
                     (rank_r[i] < slot_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      rank_nxt[op.slot] = '0;
      if (op.insert) begin
        valid_nxt[op.slot] = 1'b1;
        fill_nxt           = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lrudc_pkg::ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
      valid_r <= '0;
      fill_r  <= '0;
    end else begin
      rank_r  <= rank_nxt;
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

@@ rtl/lrudc_ctrl.sv @@
module lrudc_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lrudc_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lrudc_pkg::out_item_t                 out_data,
  output logic                                 ram_rd_en,
  output logic [lrudc_pkg::IDX_W-1:0]          ram_rd_addr,
  input  logic [lrudc_pkg::KEY_BITS-1:0]       key_rd_data,
  input  logic [lrudc_pkg::CONTENT_BITS-1:0]   content_rd_data,
  output logic                                 key_wr_en,
  output logic                                 content_wr_en,
  output logic [lrudc_pkg::IDX_W-1:0]          ram_wr_addr,
  output logic [lrudc_pkg::KEY_BITS-1:0]       key_wr_data,
  output logic [lrudc_pkg::CONTENT_BITS-1:0]   content_wr_data,
  output logic [lrudc_pkg::IDX_W-1:0]          rank_idx,
  input  logic [lrudc_pkg::RANK_W-1:0]         rank_rd,
  output lrudc_pkg::rank_op_t                  rank_op,
  input  logic [lrudc_pkg::FILL_W-1:0]         fill
);

  lrudc_pkg::state_t state_r, state_nxt;

  logic [lrudc_pkg::KEY_BITS-1:0]     key_r, key_nxt;
  logic [lrudc_pkg::CONTENT_BITS-1:0] content_r, content_nxt;
  logic [lrudc_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [lrudc_pkg::IDX_W-1:0]        slot_r, slot_nxt;
  logic [lrudc_pkg::IDX_W-1:0]        victim_r, victim_nxt;
  logic                               found_r, found_nxt;
  logic                               same_r, same_nxt;
  logic                               out_vld_r, out_vld_nxt;
  lrudc_pkg::out_item_t               out_data_r, out_data_nxt;

  logic accept;
  logic out_free;
  logic commit;
  logic key_eq;
  logic last_entry;
  logic full;

  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_vld_r || !out_stall;
  assign commit     = (state_r == lrudc_pkg::ST_FIN) && out_free;
  assign key_eq     = (key_rd_data == key_r);
  assign last_entry = ((lrudc_pkg::FILL_W'(idx_r) + lrudc_pkg::FILL_W'(1)) == fill);
  assign full       = (fill == lrudc_pkg::FILL_W'(lrudc_pkg::ENTRIES));

  assign in_stall  = (state_r != lrudc_pkg::ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign rank_idx  = idx_r;

  // Next state: a read and a compare per entry to a match, then commit.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrudc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (fill == '0) ? lrudc_pkg::ST_FIN : lrudc_pkg::ST_LOOK;
        end
      end
      lrudc_pkg::ST_LOOK: begin
        state_nxt = lrudc_pkg::ST_CMP;
      end
      lrudc_pkg::ST_CMP: begin
        state_nxt = (key_eq || last_entry) ? lrudc_pkg::ST_FIN : lrudc_pkg::ST_LOOK;
      end
      lrudc_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = lrudc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrudc_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and store controls for each state.
  always_comb begin
    key_nxt         = key_r;
    content_nxt     = content_r;
    idx_nxt         = idx_r;
    slot_nxt        = slot_r;
    victim_nxt      = victim_r;
    found_nxt       = found_r;
    same_nxt        = same_r;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = idx_r;
    key_wr_en       = 1'b0;
    content_wr_en   = 1'b0;
    ram_wr_addr     = slot_r;
    key_wr_data     = key_r;
    content_wr_data = content_r;
    rank_op         = '0;
    out_data_nxt    = out_data_r;
    out_vld_nxt     = out_vld_r && out_stall;
    case (state_r)
      lrudc_pkg::ST_IDLE: begin
        if (accept) begin
          key_nxt     = in_data.fingerprint_key[lrudc_pkg::KEY_BITS-1:0];
          content_nxt = in_data.content_word[lrudc_pkg::CONTENT_BITS-1:0];
          idx_nxt     = '0;
          victim_nxt  = '0;
          found_nxt   = 1'b0;
          same_nxt    = 1'b0;
        end
      end
      lrudc_pkg::ST_LOOK: begin
        ram_rd_en = 1'b1;
        // The least recent entry of a full store holds the top rank.
        if (rank_rd == lrudc_pkg::RANK_W'(lrudc_pkg::ENTRIES - 1)) begin
          victim_nxt = idx_r;
        end
      end
      lrudc_pkg::ST_CMP: begin
        if (key_eq) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r;
          same_nxt  = (content_rd_data == content_r);
        end else if (!last_entry) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      lrudc_pkg::ST_FIN: begin
        if (commit) begin
          out_vld_nxt = 1'b1;
          rank_op.en  = 1'b1;
          if (found_r) begin
            rank_op.slot = slot_r;
            if (same_r) begin
              out_data_nxt.hit     = 1'b1;
              out_data_nxt.outcome = lrudc_pkg::OUTCOME_HIT;
            end else begin
              content_wr_en        = 1'b1;
              out_data_nxt.hit     = 1'b0;
              out_data_nxt.outcome = lrudc_pkg::OUTCOME_REPLACE;
            end
          end else if (!full) begin
            ram_wr_addr          = fill[lrudc_pkg::IDX_W-1:0];
            key_wr_en            = 1'b1;
            content_wr_en        = 1'b1;
            rank_op.insert       = 1'b1;
            rank_op.slot         = fill[lrudc_pkg::IDX_W-1:0];
            out_data_nxt.hit     = 1'b0;
            out_data_nxt.outcome = lrudc_pkg::OUTCOME_INSERT;
          end else begin
            ram_wr_addr          = victim_r;
            key_wr_en            = 1'b1;
            content_wr_en        = 1'b1;
            rank_op.slot         = victim_r;
            out_data_nxt.hit     = 1'b0;
            out_data_nxt.outcome = lrudc_pkg::OUTCOME_EVICT;
          end
        end
      end
      default: begin
        out_vld_nxt = out_vld_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lrudc_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    content_r  <= content_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    victim_r   <= victim_nxt;
    found_r    <= found_nxt;
    same_r     <= same_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/lrudc_chk.sv @@
module lrudc_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input lrudc_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input lrudc_pkg::out_item_t out_data
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // The block is busy in the cycle after an input transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transfer");

  // No result appears in the cycle after an input transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // The hit flag agrees with the outcome code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit == (out_data.outcome == lrudc_pkg::OUTCOME_HIT)))
    else $error("hit flag and outcome disagree");

endmodule

bind lru_dedup_chunk_cache lrudc_chk u_lrudc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
